FILE: src/ripple_ring_frame_renderer_top_assert.svh
// assertion macros for the ripple ring frame renderer
`ifndef RIPPLE_RING_FRAME_RENDERER_TOP_ASSERT_SVH
`define RIPPLE_RING_FRAME_RENDERER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RRF_ASSERT_IMPL(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");
`define RRF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define RRF_ASSERT_IMPL(label, expr)
`define RRF_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: src/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// shared constants for the ripple ring frame renderer
// ----------------------------------------------------------------------------
package rrf_pkg;
    localparam int RIPPLE_SLOTS = 8;
    localparam int GRID_WIDTH   = 8;
    localparam int GRID_HEIGHT  = 8;
    localparam int SLOT_W       = (RIPPLE_SLOTS > 1) ? $clog2(RIPPLE_SLOTS) : 1;
    localparam logic [5:0]  FULL_LIFE  = 6'd50;
    localparam logic [8:0]  RING_HALF  = 9'd384;
    localparam logic [14:0] FULL_SCALE = 15'd19200;
    localparam logic [23:0] BACKGROUND = 24'h000010;
    localparam logic [14:0] RADIUS_MAX = 15'(GRID_WIDTH * 2 * 256);
    localparam logic [9:0]  DROP_RESET = 10'd50;
    localparam logic [9:0]  SPEED_RESET = 10'd64;
    localparam logic        CFG_DROP   = 1'b0;
    localparam logic        CFG_SPEED  = 1'b1;
    localparam logic [7:0]  K_RED   = 8'd100;
    localparam logic [7:0]  K_GREEN = 8'd150;
    localparam logic [7:0]  K_BLUE  = 8'd255;
    // ceil(k * 2^29 / 19200), 29 fraction bits
    localparam logic [22:0] K_RED_RCP   = 23'd2796203;
    localparam logic [22:0] K_GREEN_RCP = 23'd4194304;
    localparam logic [22:0] K_BLUE_RCP  = 23'd7130317;
endpackage

FILE: src/rrf_isqrt.sv
// ----------------------------------------------------------------------------
// rrf_isqrt
// bit-serial floor square root of a 24-bit value, two bits per cycle
// ----------------------------------------------------------------------------
module rrf_isqrt import rrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] value,
    output logic        done,
    output logic [11:0] root
);
    logic [23:0] rem_reg, rem_next;
    logic [11:0] root_reg, root_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [13:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial = {root_reg, 2'b01};
        if (start) begin
            rem_next  = value;
            root_next = '0;
            cnt_next  = 4'd12;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            busy_next = (cnt_reg != 4'd1);
            cnt_next  = cnt_reg - 4'd1;
        end
    end

    // restoring root with partial remainder kept in a separate register
    logic [13:0] prem_reg, prem_next;
    logic [13:0] shifted;
    logic [3:0]  idx;
    always_comb begin
        idx     = cnt_reg - 4'd1;
        shifted = {prem_reg[11:0], rem_reg[5'(2 * idx) + 5'd1], rem_reg[5'(2 * idx)]};
        prem_next = prem_reg;
        if (start) begin
            prem_next = '0;
        end else if (busy_reg) begin
            if (shifted >= trial) begin
                prem_next = shifted - trial;
            end else begin
                prem_next = shifted;
            end
        end
    end

    logic [11:0] root_upd;
    always_comb begin
        root_upd = (shifted >= trial) ? {root_reg[10:0], 1'b1} : {root_reg[10:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        prem_reg <= prem_next;
        if (start) begin
            root_reg <= root_next;
        end else if (busy_reg) begin
            root_reg <= root_upd;
        end
    end

    assign done = busy_reg && (cnt_reg == 4'd1) && !start;
    assign root = root_upd;
endmodule

FILE: src/ripple_ring_frame_renderer_top.sv
// ----------------------------------------------------------------------------
// ripple_ring_frame_renderer_top
// per-frame ripple spawn, ring rendering of an 8x8 grid and ripple aging
// ----------------------------------------------------------------------------
// One frame word yields 64 pixel words in raster order (x outer). Each pixel
// visits every slot in turn; an active slot runs the shared 12-step square root
// unit, an idle slot is only passed over in ST_SLOT. Colour then takes the three
// channels in turn through ST_COLOR and the pixel word waits in ST_OUT until
// m_tready; the root unit dominates the frame time. s_tready is low for the
// whole frame.
`include "ripple_ring_frame_renderer_top_assert.svh"
module ripple_ring_frame_renderer_top import rrf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // random_draw[9:0], spawn_x[12:10], spawn_y[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_x[2:0], pixel_y[5:3], pixel_color[29:6]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_COLOR = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_AGE   = 3'd5;

    logic [2:0]  state_reg;
    logic [9:0]  drop_reg, speed_reg;
    logic [RIPPLE_SLOTS-1:0] act_reg;
    logic [2:0]  cx_reg [RIPPLE_SLOTS];
    logic [2:0]  cy_reg [RIPPLE_SLOTS];
    logic [13:0] rad_reg [RIPPLE_SLOTS];
    logic [5:0]  life_reg [RIPPLE_SLOTS];
    logic [2:0]  px_reg, py_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [15:0] sum_reg;
    logic [14:0] s_reg;
    logic [1:0]  ch_reg;
    logic [7:0]  red_reg, grn_reg, blu_reg;
    logic [23:0] color;
    logic        last_reg;

    logic [3:0]  dx, dy;
    logic [6:0]  dsq;
    logic        rt_start, rt_done;
    logic [11:0] rt_root;
    logic [13:0] rdist;
    logic [14:0] d15;
    logic [15:0] contrib;
    logic [15:0] acc;
    logic [14:0] acc_sat;

    always_comb begin
        dx = (px_reg >= cx_reg[slot_reg]) ? 4'(px_reg - cx_reg[slot_reg])
                                          : 4'(cx_reg[slot_reg] - px_reg);
        dy = (py_reg >= cy_reg[slot_reg]) ? 4'(py_reg - cy_reg[slot_reg])
                                          : 4'(cy_reg[slot_reg] - py_reg);
        dsq = {3'd0, dx} * {3'd0, dx} + {3'd0, dy} * {3'd0, dy};
        d15 = {3'd0, rt_root};
        rdist = (d15 >= {1'b0, rad_reg[slot_reg]}) ? 14'(d15 - {1'b0, rad_reg[slot_reg]})
                                                   : 14'({1'b0, rad_reg[slot_reg]} - d15);
        contrib = {7'd0, RING_HALF - rdist[8:0]} * {10'd0, life_reg[slot_reg]};
        // running sum saturates at full scale
        acc = sum_reg + ((rdist < 14'(RING_HALF)) ? contrib : 16'd0);
        acc_sat = (acc > {1'b0, FULL_SCALE}) ? FULL_SCALE : acc[14:0];
    end

    assign rt_start = (state_reg == ST_SLOT) && act_reg[slot_reg];

    rrf_isqrt u_root (
        .aclk, .aresetn, .start(rt_start), .value({1'b0, dsq, 16'd0}),
        .done(rt_done), .root(rt_root)
    );

    // colour channels by one shared multiply with a per-channel reciprocal
    logic [22:0] krcp;
    logic [37:0] prod;
    logic [7:0]  quo;
    always_comb begin
        case (ch_reg)
            2'd0:    krcp = K_RED_RCP;
            2'd1:    krcp = K_GREEN_RCP;
            default: krcp = K_BLUE_RCP;
        endcase
        prod = {23'd0, s_reg} * {15'd0, krcp};
        quo  = prod[36:29];
    end
    assign color = (s_reg == 15'd0) ? BACKGROUND : {red_reg, grn_reg, blu_reg};

    logic [2:0] sx, sy;
    logic [SLOT_W-1:0] free_idx;
    logic free_any;
    always_comb begin
        sx = (s_tdata[12:10] > 3'(GRID_WIDTH - 1)) ? 3'(GRID_WIDTH - 1) : s_tdata[12:10];
        sy = (s_tdata[15:13] > 3'(GRID_HEIGHT - 1)) ? 3'(GRID_HEIGHT - 1) : s_tdata[15:13];
        free_idx = '0;
        free_any = 1'b0;
        for (int i = RIPPLE_SLOTS - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [14:0] nrad;
    logic [5:0]  nlife;
    always_comb begin
        nrad  = {1'b0, rad_reg[slot_reg]} + {5'd0, speed_reg};
        nlife = (life_reg[slot_reg] != 6'd0) ? life_reg[slot_reg] - 6'd1 : 6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            drop_reg  <= DROP_RESET;
            speed_reg <= SPEED_RESET;
            act_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index[0])
                    CFG_DROP:  drop_reg  <= cfg_data;
                    CFG_SPEED: speed_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata[9:0] < drop_reg && free_any) begin
                            act_reg[free_idx]  <= 1'b1;
                            cx_reg[free_idx]   <= sx;
                            cy_reg[free_idx]   <= sy;
                            rad_reg[free_idx]  <= '0;
                            life_reg[free_idx] <= FULL_LIFE;
                        end
                        px_reg <= '0; py_reg <= '0; slot_reg <= '0; sum_reg <= '0;
                        state_reg <= ST_SLOT;
                    end
                end
                ST_SLOT: begin
                    if (act_reg[slot_reg]) begin
                        state_reg <= ST_ROOT;
                    end else if (slot_reg == SLOT_W'(RIPPLE_SLOTS - 1)) begin
                        state_reg <= ST_COLOR;
                        ch_reg <= 2'd0;
                        s_reg <= sum_reg[14:0];
                    end else begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                ST_ROOT: begin
                    if (rt_done) begin
                        sum_reg <= {1'b0, acc_sat};
                        if (slot_reg == SLOT_W'(RIPPLE_SLOTS - 1)) begin
                            state_reg <= ST_COLOR;
                            ch_reg <= 2'd0;
                            s_reg <= acc_sat;
                        end else begin
                            slot_reg <= slot_reg + SLOT_W'(1);
                            state_reg <= ST_SLOT;
                        end
                    end
                end
                ST_COLOR: begin
                    case (ch_reg)
                        2'd0: red_reg <= quo;
                        2'd1: grn_reg <= quo;
                        default: blu_reg <= quo;
                    endcase
                    ch_reg <= ch_reg + 2'd1;
                    if (ch_reg == 2'd2) begin
                        state_reg <= ST_OUT;
                        last_reg <= (px_reg == 3'(GRID_WIDTH - 1)) &&
                                    (py_reg == 3'(GRID_HEIGHT - 1));
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        slot_reg <= '0;
                        sum_reg  <= '0;
                        if (last_reg) begin
                            state_reg <= ST_AGE;
                        end else begin
                            state_reg <= ST_SLOT;
                            if (py_reg == 3'(GRID_HEIGHT - 1)) begin
                                py_reg <= '0;
                                px_reg <= px_reg + 3'd1;
                            end else begin
                                py_reg <= py_reg + 3'd1;
                            end
                        end
                    end
                end
                ST_AGE: begin
                    if (act_reg[slot_reg]) begin
                        rad_reg[slot_reg]  <= nrad[13:0];
                        life_reg[slot_reg] <= nlife;
                        if (nlife == 6'd0 || {1'b0, nrad[13:0]} > RADIUS_MAX)
                            act_reg[slot_reg] <= 1'b0;
                    end
                    if (slot_reg == SLOT_W'(RIPPLE_SLOTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, color, py_reg, px_reg};

    `RRF_ASSERT_IMPL(a_one_side, !(s_tready && m_tvalid))
    `RRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RRF_ASSERT_NEXT(a_last_age, m_tvalid && m_tready && m_tlast, state_reg == ST_AGE)
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// frame words with random spawn draws go in, each gives 64 pixel words that a
// built-in ripple predictor checks field by field; both rates are written
// between frames, the extremes among them
// ----------------------------------------------------------------------------
module testbench import rrf_pkg::*; ();

    class pixel_board;
        logic [9:0]  drop_rate;
        logic [9:0]  speed;
        bit          active [RIPPLE_SLOTS];
        int unsigned cx [RIPPLE_SLOTS];
        int unsigned cy [RIPPLE_SLOTS];
        int unsigned radius [RIPPLE_SLOTS];
        int unsigned life [RIPPLE_SLOTS];
        logic [30:0] pending [$];
        int          errors;

        function new();
            drop_rate = DROP_RESET;
            speed = SPEED_RESET;
            errors = 0;
            foreach (active[i]) active[i] = 0;
        endfunction

        function int unsigned isqrt(int unsigned v);
            longint unsigned r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return 32'(r);
        endfunction

        function void note_frame(logic [9:0] draw, logic [2:0] sx, logic [2:0] sy);
            int unsigned s, d, r, col;
            int dx, dy;
            if (draw < drop_rate) begin
                for (int i = 0; i < RIPPLE_SLOTS; i++) begin
                    if (!active[i]) begin
                        active[i] = 1;
                        cx[i] = (sx > GRID_WIDTH - 1) ? GRID_WIDTH - 1 : sx;
                        cy[i] = (sy > GRID_HEIGHT - 1) ? GRID_HEIGHT - 1 : sy;
                        radius[i] = 0;
                        life[i] = FULL_LIFE;
                        break;
                    end
                end
            end
            for (int x = 0; x < GRID_WIDTH; x++) begin
                for (int y = 0; y < GRID_HEIGHT; y++) begin
                    s = 0;
                    for (int i = 0; i < RIPPLE_SLOTS; i++) begin
                        if (active[i]) begin
                            dx = x - int'(cx[i]);
                            dy = y - int'(cy[i]);
                            d = isqrt((dx * dx + dy * dy) * 65536);
                            r = (d >= radius[i]) ? d - radius[i] : radius[i] - d;
                            if (r < RING_HALF) s += (RING_HALF - r) * life[i];
                        end
                    end
                    if (s > FULL_SCALE) s = FULL_SCALE;
                    if (s > 0)
                        col = ((K_RED * s / FULL_SCALE) << 16)
                            | ((K_GREEN * s / FULL_SCALE) << 8) | (K_BLUE * s / FULL_SCALE);
                    else
                        col = BACKGROUND;
                    pending.push_back({(x == GRID_WIDTH - 1 && y == GRID_HEIGHT - 1),
                                       col[23:0], 3'(y), 3'(x)});
                end
            end
            for (int i = 0; i < RIPPLE_SLOTS; i++) begin
                if (active[i]) begin
                    radius[i] = (radius[i] + speed) & 16'h3fff;
                    life[i] = (life[i] > 0) ? life[i] - 1 : 0;
                    if (life[i] == 0 || radius[i] > RADIUS_MAX) active[i] = 0;
                end
            end
        endfunction

        task check_pixel(logic [31:0] data, logic last);
            logic [30:0] want;
            if (pending.size() == 0) begin
                report("pixel word with nothing expected", 0, data);
                return;
            end
            want = pending.pop_front();
            if (data[2:0] != want[2:0]) report("pixel_x", want[2:0], data[2:0]);
            if (data[5:3] != want[5:3]) report("pixel_y", want[5:3], data[5:3]);
            if (data[29:6] != want[29:6]) report("pixel_color", want[29:6], data[29:6]);
            if (last != want[30]) report("last_pixel", want[30], last);
        endtask

        task report(string what, longint unsigned want, longint unsigned got);
            $display("mismatch %s: expected %0h got %0h", what, want, got);
            errors++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [9:0]  cfg_data;

    pixel_board board;
    int          idle_pct;
    int          quiet_cycles;

    ripple_ring_frame_renderer_top dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    task automatic write_rate(logic [0:0] idx, logic [9:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == CFG_DROP) board.drop_rate = value;
        else board.speed = value;
        @(posedge aclk);
    endtask

    task automatic send_frame(logic [9:0] draw, logic [2:0] sx, logic [2:0] sy);
        while ($urandom_range(99) < idle_pct) @(posedge aclk);
        s_tvalid <= 1;
        s_tdata <= {sy, sx, draw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_frame(draw, sx, sy);
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_frames(int count, int hot);
        for (int n = 0; n < count; n++)
            if ($urandom_range(99) < hot)
                send_frame(10'($urandom_range(hot * 10)), 3'($urandom), 3'($urandom));
            else
                send_frame(10'($urandom_range(1023)), 3'($urandom), 3'($urandom));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tlast);
        m_tready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 40000) begin
            $display("[ripple_ring_frame_renderer_top] ERROR");
            $finish;
        end
    end

    initial begin
        board = new();
        idle_pct = 25;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= 0;
        cfg_we <= 0;
        cfg_index <= CFG_DROP;
        cfg_data <= 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset rates, spawn at extremes and out-of-range draws
        send_frame(10'd0, 3'd0, 3'd0);
        send_frame(10'd49, 3'd7, 3'd7);
        send_frame(10'd50, 3'd3, 3'd4);
        send_frame(10'd1023, 3'd5, 3'd2);
        drain();
        write_rate(CFG_DROP, 10'd1023);
        write_rate(CFG_SPEED, 10'd0);
        for (int i = 0; i < 10; i++) send_frame(10'(i * 100), 3'(i), 3'(7 - i));
        drain();
        write_rate(CFG_SPEED, 10'd1023);
        for (int i = 0; i < 6; i++) send_frame(10'd1022, 3'(i + 2), 3'(i));
        drain();
        write_rate(CFG_DROP, 10'd0);
        send_frame(10'd0, 3'd1, 3'd1);
        drain();

        write_rate(CFG_DROP, 10'd500);
        write_rate(CFG_SPEED, 10'd64);
        idle_pct = 0;
        random_frames(20, 50);
        drain();
        idle_pct = 25;
        write_rate(CFG_DROP, 10'd1000);
        write_rate(CFG_SPEED, 10'($urandom_range(1023)));
        random_frames(30, 100);
        drain();
        write_rate(CFG_DROP, 10'($urandom_range(1000)));
        write_rate(CFG_SPEED, 10'($urandom_range(300)));
        random_frames(30, 30);
        drain();

        while (m_tready !== 1'b1) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ripple_ring_frame_renderer_top] OK");
        else
            $display("[ripple_ring_frame_renderer_top] ERROR");
        $finish;
    end

endmodule

FILE: ripple_ring_frame_renderer_top.f
+incdir+src
src/rrf_pkg.sv
src/rrf_isqrt.sv
src/ripple_ring_frame_renderer_top.sv
bench/testbench.sv
